// File: hdl/swm_pkg.sv
// Shared package of the sliding-window median filter.
// Holds default sizes, register constants and the controller/datapath link types.
package swm_pkg;

	localparam int MAX_WINDOW_DEF   = 32;
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int CFG_WIDTH        = 6;
	localparam logic [CFG_WIDTH-1:0] WINDOW_LENGTH_RESET = 6'd5;

	typedef struct packed {
		logic accept;
		logic sort_step;
		logic shift_step;
		logic emit;
	} swm_cmd_t;

	typedef struct packed {
		logic need_result;
		logic sort_last;
		logic shift_done;
	} swm_sts_t;

endpackage

// File: hdl/swm_ctrl.sv
// Controller of the sliding-window median filter.
// Sequences accept, sort, select and output steps; uses swm_pkg.
module swm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output swm_pkg::swm_cmd_t cmd,
	input  swm_pkg::swm_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SORT,
		ST_SHIFT,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd            = '0;
		cmd.accept     = (state_q == ST_IDLE) && in_valid;
		cmd.sort_step  = (state_q == ST_SORT);
		cmd.shift_step = (state_q == ST_SHIFT) && !sts.shift_done;
		cmd.emit       = (state_q == ST_EMIT) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && sts.need_result) begin
						state_q <= ST_SORT;
					end
				end
				ST_SORT: begin
					if (sts.sort_last) begin
						state_q <= ST_SHIFT;
					end
				end
				ST_SHIFT: begin
					if (sts.shift_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: hdl/swm_datapath.sv
// Datapath of the sliding-window median filter: window shift line, sorting cells,
// fill and step counters, window length register and result register; uses swm_pkg.
module swm_datapath #(
	parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [swm_pkg::CFG_WIDTH-1:0]   cfg_wdata,
	input  logic signed [SAMPLE_WIDTH-1:0]  sample,
	input  logic                            eor,
	input  swm_pkg::swm_cmd_t               cmd,
	output swm_pkg::swm_sts_t               sts,
	output logic signed [SAMPLE_WIDTH:0]    median,
	output logic                            last
);

	localparam int KW  = $clog2(MAX_WINDOW + 1);
	localparam int HI1 = (MAX_WINDOW > 1) ? 1 : 0;

	logic signed [SAMPLE_WIDTH-1:0] win_q [MAX_WINDOW];
	logic signed [SAMPLE_WIDTH-1:0] win_nxt [MAX_WINDOW];
	logic signed [SAMPLE_WIDTH-1:0] srt_q [MAX_WINDOW];
	logic signed [SAMPLE_WIDTH-1:0] srt_sort [MAX_WINDOW];
	logic [swm_pkg::CFG_WIDTH-1:0]  wl_q;
	logic [KW-1:0]                  fill_q;
	logic [KW-1:0]                  fill_inc;
	logic [KW-1:0]                  cnt_q;
	logic [KW-1:0]                  eff_k;
	logic [KW-1:0]                  half_k;
	logic                           eor_q;
	logic signed [SAMPLE_WIDTH:0]   median_q;
	logic                           last_q;
	logic signed [SAMPLE_WIDTH:0]   med_lo;
	logic signed [SAMPLE_WIDTH:0]   med_hi;

	always_comb begin
		if (wl_q == '0) begin
			eff_k = KW'(1);
		end else if (32'(wl_q) > MAX_WINDOW) begin
			eff_k = KW'(MAX_WINDOW);
		end else begin
			eff_k = KW'(wl_q);
		end
	end

	assign half_k   = (eff_k - KW'(1)) >> 1;
	assign fill_inc = (fill_q == KW'(MAX_WINDOW)) ? fill_q : fill_q + KW'(1);

	assign sts.need_result = (fill_inc >= eff_k);
	assign sts.sort_last   = (cnt_q == eff_k - KW'(1));
	assign sts.shift_done  = (cnt_q == half_k);

	always_comb begin
		win_nxt[0] = sample;
		for (int i = 1; i < MAX_WINDOW; i++) begin
			win_nxt[i] = win_q[i-1];
		end
	end

	// One pass of odd-even transposition over the first k cells.
	always_comb begin
		for (int i = 0; i < MAX_WINDOW; i++) begin
			srt_sort[i] = srt_q[i];
		end
		for (int j = 0; j < MAX_WINDOW - 1; j++) begin
			if ((j % 2) == int'(cnt_q[0]) && (j + 1) < int'(eff_k)) begin
				if (srt_q[j] > srt_q[j+1]) begin
					srt_sort[j]   = srt_q[j+1];
					srt_sort[j+1] = srt_q[j];
				end
			end
		end
	end

	assign med_lo = {srt_q[0][SAMPLE_WIDTH-1], srt_q[0]};
	assign med_hi = {srt_q[HI1][SAMPLE_WIDTH-1], srt_q[HI1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q   <= swm_pkg::WINDOW_LENGTH_RESET;
			fill_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (cfg_we) begin
				wl_q <= cfg_wdata;
			end
			if (cmd.accept) begin
				fill_q <= eor ? '0 : fill_inc;
				cnt_q  <= '0;
			end else if (cmd.sort_step) begin
				cnt_q <= sts.sort_last ? '0 : cnt_q + KW'(1);
			end else if (cmd.shift_step) begin
				cnt_q <= cnt_q + KW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				win_q[i] <= win_nxt[i];
				srt_q[i] <= win_nxt[i];
			end
			eor_q <= eor;
		end else if (cmd.sort_step) begin
			for (int i = 0; i < MAX_WINDOW; i++) begin
				srt_q[i] <= srt_sort[i];
			end
		end else if (cmd.shift_step) begin
			for (int i = 0; i < MAX_WINDOW - 1; i++) begin
				srt_q[i] <= srt_q[i+1];
			end
		end
		if (cmd.emit) begin
			median_q <= eff_k[0] ? (med_lo <<< 1) : (med_lo + med_hi);
			last_q   <= eor_q;
		end
	end

	assign median = median_q;
	assign last   = last_q;

endmodule

// File: hdl/sliding_window_median.sv
// Top level of the sliding-window median filter.
// Joins swm_ctrl and swm_datapath; uses swm_pkg.
//
// Samples arrive on the s_ stream channel, one signed sample per transaction,
// with s_tlast marking the last sample of a record. Once k samples of the
// record are held (k from window_length, zero read as one, values above
// MAX_WINDOW read as MAX_WINDOW), each sample yields one transaction on the
// m_ channel carrying twice the median of the last k samples; m_tlast copies
// the s_tlast of the sample that produced it. After a sample with s_tlast
// the window is empty again.
// A sample that yields no result is taken while the block stays idle. A sample
// that yields a result holds off the next sample until it has passed through
// the accepting step, k passes of the odd-even transposition sorting cells,
// (k-1)/2 shifts that bring the middle value to the front plus one step that
// ends them, and the load of the output register once it is free. The output register
// decouples the sides: a waiting result does not block the next sample, but a
// further result waits in the controller until the receiver takes the previous one.
// Reset clears the window fill, the output valid and sets window_length to 5.
// The user writes window_length with window_length_we only while the block is idle; the block does not enforce it.
module sliding_window_median #(
	parameter int MAX_WINDOW   = swm_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_WIDTH = swm_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    window_length_we,
	input  logic [swm_pkg::CFG_WIDTH-1:0]           window_length,
	input  logic                                    s_tvalid,
	output logic                                    s_tready,
	input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]       s_tdata,  // sample
	input  logic                                    s_tlast,  // end_of_record
	output logic                                    m_tvalid,
	input  logic                                    m_tready,
	output logic [((SAMPLE_WIDTH+8)/8)*8-1:0]       m_tdata,  // median_half_units
	output logic                                    m_tlast   // last_of_record
);

	localparam int OW = ((SAMPLE_WIDTH + 8) / 8) * 8;

	swm_pkg::swm_cmd_t            cmd;
	swm_pkg::swm_sts_t            sts;
	logic signed [SAMPLE_WIDTH:0] median;

	swm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	swm_datapath #(
		.MAX_WINDOW   (MAX_WINDOW),
		.SAMPLE_WIDTH (SAMPLE_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (window_length_we),
		.cfg_wdata (window_length),
		.sample    (s_tdata[SAMPLE_WIDTH-1:0]),
		.eor       (s_tlast),
		.cmd       (cmd),
		.sts       (sts),
		.median    (median),
		.last      (m_tlast)
	);

	assign m_tdata = OW'(unsigned'(median));

	a_no_result_free: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !sts.need_result) |=> s_tready)
		else $error("input held off after a sample without result");

	a_result_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && sts.need_result) |=> !s_tready)
		else $error("input taken while a result is being computed");

	a_emit_after_sort: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !cmd.accept && !cmd.sort_step && !cmd.shift_step)
		else $error("result emitted alongside another datapath step");

endmodule
